// File: design/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMD_W     = 2;
  localparam int RANK_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } sst_cmd_t;

  // Per-cell control broadcast by the top level each cycle
  typedef struct packed {
    logic ins_en;    // insert takes effect this cycle
    logic ers_en;    // erase takes effect this cycle
    logic occupied;  // cell index is below the stored count
    logic left_lt;   // left neighbor holds a key below the request key (or cell is first)
  } sst_cell_ctrl_t;

  // Compare flags returned by each cell
  typedef struct packed {
    logic lt;  // occupied and stored key below the request key
    logic eq;  // occupied and stored key equal to the request key
  } sst_cell_flag_t;

endpackage

// File: design/sorted_set_table.sv
`timescale 1ns / 1ps

// Sorted set of up to 16 distinct 32-bit keys held in ascending order in a row
// of compare-and-shift cells. For each request (insert, erase, get at rank)
// every cell compares its key with the request key at once and loads, shifts
// up, shifts down or holds in the same edge, so a request is accepted in every
// cycle in which the output register is empty or being drained. One result
// follows each request in the output register, valid from the cycle after
// acceptance. Insert fails when the set is full (count at or above the smaller
// of capacity_limit and 16) or the key is present; erase fails when the key is
// absent; get fails when rank_index is not below the count, and read_key is 0
// for every result except a successful get. Command 3 changes nothing and
// reports failure. capacity_limit resets to 16 and may be written only while
// no request is in flight.
module sorted_set_table
  import sst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_en,
  input  logic [CNT_W-1:0]     cfg_write_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     command,
  input  logic [KEY_WIDTH-1:0] key_value,
  input  logic [RANK_W-1:0]    rank_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 success,
  output logic [KEY_WIDTH-1:0] read_key,
  output logic [CNT_W-1:0]     key_count
);

  logic [CNT_W-1:0]     capacity_limit;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [CNT_W-1:0]     eff_cap;
  logic                 accept;
  logic                 present;
  logic                 ins_ok;
  logic                 ers_ok;
  logic                 get_ok;
  logic                 op_ok;
  logic [KEY_WIDTH-1:0] get_key;
  logic [KEY_WIDTH-1:0] rd_key;
  sst_cmd_t             cmd;

  logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
  sst_cell_flag_t       cell_flag [DEPTH];
  sst_cell_ctrl_t       cell_ctrl [DEPTH];

  assign cmd      = sst_cmd_t'(command);
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CNT_W'(DEPTH);
    end else if (cfg_write_en) begin
      capacity_limit <= cfg_write_data;
    end
  end

  assign eff_cap = (capacity_limit < CNT_W'(DEPTH)) ? capacity_limit : CNT_W'(DEPTH);

  // Gather match flags across the row
  always_comb begin
    present = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      present = present | cell_flag[i].eq;
    end
  end

  // Select the key at the requested rank
  always_comb begin
    get_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (rank_index == RANK_W'(i)) begin
        get_key = cell_key[i];
      end
    end
  end

  // Decide the outcome of the request
  always_comb begin
    ins_ok = 1'b0;
    ers_ok = 1'b0;
    get_ok = 1'b0;
    case (cmd)
      CMD_INSERT: ins_ok = (count < eff_cap) && !present;
      CMD_ERASE:  ers_ok = present;
      CMD_GET:    get_ok = {1'b0, rank_index} < count;
      default:    ;
    endcase
    op_ok  = ins_ok || ers_ok || get_ok;
    rd_key = get_ok ? get_key : '0;
  end

  // Update the stored count
  always_comb begin
    count_next = count;
    if (accept && ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (accept && ers_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_k;
    logic [KEY_WIDTH-1:0] right_k;

    if (g == 0) begin : g_first
      assign left_k = key_value;
      assign cell_ctrl[g].left_lt = 1'b1;
    end else begin : g_mid
      assign left_k = cell_key[g-1];
      assign cell_ctrl[g].left_lt = cell_flag[g-1].lt;
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_k = cell_key[g];
    end else begin : g_inner
      assign right_k = cell_key[g+1];
    end

    assign cell_ctrl[g].ins_en   = accept && ins_ok;
    assign cell_ctrl[g].ers_en   = accept && ers_ok;
    assign cell_ctrl[g].occupied = CNT_W'(g) < count;

    sst_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[g]),
      .in_key    (key_value),
      .left_key  (left_k),
      .right_key (right_k),
      .key       (cell_key[g]),
      .flag      (cell_flag[g])
    );
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      success   <= op_ok;
      read_key  <= rd_key;
      key_count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stored count above depth");

  a_count_shown: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_count == count)
    else $error("reported count differs from stored count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && ins_ok |=> count == $past(count) + CNT_W'(1))
    else $error("count did not grow on insert");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("request without result");
`endif

endmodule

// File: design/sst_cell.sv
`timescale 1ns / 1ps

module sst_cell
  import sst_pkg::*;
(
  input  logic                 clk,
  input  sst_cell_ctrl_t       ctrl,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [KEY_WIDTH-1:0] right_key,
  output logic [KEY_WIDTH-1:0] key,
  output sst_cell_flag_t       flag
);

  logic [KEY_WIDTH-1:0] key_next;

  // Compare own key against the request key
  always_comb begin
    flag.lt = ctrl.occupied && (key < in_key);
    flag.eq = ctrl.occupied && (key == in_key);
  end

  // Keep smaller keys; at and above the sorted place load, shift up or shift down
  always_comb begin
    key_next = key;
    if (ctrl.ins_en && !flag.lt) begin
      if (ctrl.left_lt) begin
        key_next = in_key;
      end else begin
        key_next = left_key;
      end
    end else if (ctrl.ers_en && !flag.lt) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// File: verif/tb_sorted_set_table.sv
`timescale 1ns / 1ps

module tb_sorted_set_table;
  import sst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    sst_cmd_t              cmd;
    logic [KEY_WIDTH-1:0]  key;
    logic [RANK_W-1:0]     rank;
  } request_t;

  typedef struct packed {
    logic                  passed;
    logic [KEY_WIDTH-1:0]  key;
    logic [CNT_W-1:0]      count;
  } result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CNT_W-1:0]     cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     command = '0;
  logic [KEY_WIDTH-1:0] key_value = '0;
  logic [RANK_W-1:0]    rank_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 success;
  logic [KEY_WIDTH-1:0] read_key;
  logic [CNT_W-1:0]     key_count;

  // Predicted set contents and the capacity setting the block should hold
  logic [KEY_WIDTH-1:0] set_keys [DEPTH];
  int                   set_count = 0;
  logic [CNT_W-1:0]     cap_limit = CNT_W'(16);

  request_t             pending_requests [$];
  result_t              expected_results [$];
  logic [KEY_WIDTH-1:0] key_pool [POOL_SIZE];
  logic [CNT_W-1:0]     phase_caps [PHASES] = '{5'd31, 5'd4, 5'd16, 5'd0, 5'd9,
                                                5'd1, 5'd17, 5'd16, 5'd2, 5'd12};
  int                   issued = 0;
  int                   results_seen = 0;
  int                   gap_left = 0;
  int                   ready_hold = 0;
  int                   cycles = 0;
  bit                   calm = 1'b0;
  bit                   failed = 1'b0;

  sorted_set_table dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .key_value      (key_value),
    .rank_index     (rank_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .success        (success),
    .read_key       (read_key),
    .key_count      (key_count)
  );

  always #10 clk = ~clk;

  // Apply one request to the predicted set and return the result it should give
  function automatic result_t apply_request(request_t r);
    result_t res;
    int      pos;
    int      room;
    res  = '0;
    room = (int'(cap_limit) < DEPTH) ? int'(cap_limit) : DEPTH;
    pos  = 0;
    while (pos < set_count && set_keys[pos] < r.key) pos++;
    case (r.cmd)
      CMD_INSERT: begin
        if (set_count < room && !(pos < set_count && set_keys[pos] == r.key)) begin
          for (int k = set_count; k > pos; k--) set_keys[k] = set_keys[k-1];
          set_keys[pos] = r.key;
          set_count++;
          res.passed = 1'b1;
        end
      end
      CMD_ERASE: begin
        if (pos < set_count && set_keys[pos] == r.key) begin
          for (int k = pos; k + 1 < set_count; k++) set_keys[k] = set_keys[k+1];
          set_count--;
          res.passed = 1'b1;
        end
      end
      CMD_GET: begin
        if (int'(r.rank) < set_count) begin
          res.passed = 1'b1;
          res.key    = set_keys[r.rank];
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(set_count);
    return res;
  endfunction

  // Draw a request: mostly keys from a small pool so hits and duplicates are common
  function automatic request_t random_request(int ins_pct);
    request_t r;
    int       roll;
    roll = $urandom_range(0, 99);
    if (roll < 4)
      r.cmd = CMD_NONE;
    else if (roll < 4 + ins_pct)
      r.cmd = CMD_INSERT;
    else if (roll < 4 + ins_pct + (96 - ins_pct) / 2)
      r.cmd = CMD_ERASE;
    else
      r.cmd = CMD_GET;
    if ($urandom_range(0, 3) != 0)
      r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else
      r.key = $urandom;
    r.rank = $urandom_range(0, DEPTH - 1);
    return r;
  endfunction

  task automatic push_request(sst_cmd_t cmd, logic [KEY_WIDTH-1:0] key,
                              logic [RANK_W-1:0] rank);
    request_t r;
    r.cmd  = cmd;
    r.key  = key;
    r.rank = rank;
    pending_requests.push_back(r);
    issued++;
  endtask

  // Wait until every issued request has produced its result, then let the block settle
  task automatic wait_idle();
    while (results_seen != issued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    cap_limit      = value;
    @(posedge clk);
  endtask

  // Drive requests from the pending queue, predicting each one as it is accepted
  always @(posedge clk) begin : request_driver
    request_t next_req;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(apply_request({sst_cmd_t'(command), key_value, rank_index}));
      if (in_valid && !in_ready) begin
        // hold the request until it is taken
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        next_req   = pending_requests.pop_front();
        command    <= next_req.cmd;
        key_value  <= next_req.key;
        rank_index <= next_req.rank;
        in_valid   <= 1'b1;
        gap_left   <= calm ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Check each result against the oldest prediction and stall the output at random
  always @(posedge clk) begin : result_monitor
    result_t want;
    int      hold;
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got success %0d key %h count %0d",
                   $time, success, read_key, key_count);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (success !== want.passed) begin
            $display("%0t: success mismatch: expected %0d, got %0d",
                     $time, want.passed, success);
            failed = 1'b1;
          end
          if (read_key !== want.key) begin
            $display("%0t: read_key mismatch: expected %h, got %h", $time, want.key, read_key);
            failed = 1'b1;
          end
          if (key_count !== want.count) begin
            $display("%0t: key_count mismatch: expected %0d, got %0d",
                     $time, want.count, key_count);
            failed = 1'b1;
          end
        end
        hold = calm ? 0 : $urandom_range(0, 3);
        out_ready  <= (hold == 0);
        ready_hold <= hold;
      end else if (!out_ready) begin
        if (ready_hold <= 1) begin
          out_ready  <= 1'b1;
          ready_hold <= 0;
        end else begin
          ready_hold <= ready_hold - 1;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int ins_pct;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty set, ordering at both key extremes, duplicates and misses
    push_request(CMD_GET,    32'h0, 4'd0);
    push_request(CMD_ERASE,  32'd5, 4'd0);
    push_request(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
    push_request(CMD_INSERT, 32'h0, 4'd15);
    push_request(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
    push_request(CMD_INSERT, 32'd7, 4'd0);
    push_request(CMD_INSERT, 32'd3, 4'd0);
    push_request(CMD_GET,    32'hFFFF_FFFF, 4'd0);
    push_request(CMD_GET,    32'h0, 4'd3);
    push_request(CMD_GET,    32'h0, 4'd15);
    push_request(CMD_GET,    32'h0, 4'd4);
    push_request(CMD_NONE,   32'hAAAA_5555, 4'd5);
    push_request(CMD_ERASE,  32'd3, 4'd0);
    push_request(CMD_ERASE,  32'hFFFF_FFFF, 4'd0);
    push_request(CMD_ERASE,  32'h0, 4'd0);
    push_request(CMD_ERASE,  32'h0, 4'd0);
    push_request(CMD_GET,    32'h0, 4'd0);

    // Full set at a small capacity
    set_capacity(5'd2);
    push_request(CMD_INSERT, 32'd9, 4'd0);
    push_request(CMD_INSERT, 32'd1, 4'd0);

    // Capacity dropped below the stored count: inserts refused, erase and get still work
    set_capacity(5'd1);
    push_request(CMD_INSERT, 32'd8, 4'd0);
    push_request(CMD_GET,    32'd0, 4'd1);
    push_request(CMD_ERASE,  32'd7, 4'd0);

    // Zero capacity refuses every insert
    set_capacity(5'd0);
    push_request(CMD_INSERT, 32'd5, 4'd0);
    push_request(CMD_ERASE,  32'd9, 4'd0);

    // Capacity above the store depth
    set_capacity(5'd31);
    push_request(CMD_INSERT, 32'h5555_AAAA, 4'd0);
    push_request(CMD_GET,    32'h0, 4'd0);

    // Random phases, each at its own capacity and mix, two of them without stalls
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      calm = (p == 2 || p == 7);
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 32'd1;
      key_pool[3] = 32'hFFFF_FFFE;
      ins_pct = $urandom_range(30, 60);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        request_t r;
        r = random_request(ins_pct);
        push_request(r.cmd, r.key, r.rank);
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
design/sst_pkg.sv
design/sst_cell.sv
design/sorted_set_table.sv
verif/tb_sorted_set_table.sv
